@@ hdl/mbaf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbaf_pkg
// Shared constants, codes and types of the masked box average filter.
// ----------------------------------------------------------------------------
package mbaf_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HALF_DEF  = 2;
    localparam int MAX_HEIGHT    = 4096;

    localparam int CELL_W     = 8;
    localparam int COL_OUT_W  = 10;
    localparam int ROW_W      = 12;
    localparam int GW_W       = 11;
    localparam int GH_W       = 13;
    localparam int HW_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [GW_W-1:0] GRID_WIDTH_RST  = 11'd1024;
    localparam logic [GH_W-1:0] GRID_HEIGHT_RST = 13'd1024;
    localparam logic [HW_W-1:0] HALF_WINDOW_RST = 2'd1;

    localparam logic signed [CELL_W-1:0] UNKNOWN_CELL = -8'sd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_HALF_WINDOW = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

@@ hdl/mbaf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbaf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/mbaf_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbaf_cell
// One window column: holds the column sum and known count, hands them to the
// next cell on shift, and when enabled adds them to the running window total.
// ----------------------------------------------------------------------------
module mbaf_cell #(
    parameter int COL_SUM_W = 11,
    parameter int COL_CNT_W = 3,
    parameter int WIN_SUM_W = 13,
    parameter int WIN_CNT_W = 5
) (
    input  logic                        aclk,
    input  logic                        shift,
    input  logic                        use_en,
    input  logic signed [COL_SUM_W-1:0] col_sum_in,
    input  logic        [COL_CNT_W-1:0] col_cnt_in,
    input  logic signed [WIN_SUM_W-1:0] acc_sum_in,
    input  logic        [WIN_CNT_W-1:0] acc_cnt_in,
    output logic signed [COL_SUM_W-1:0] col_sum_out,
    output logic        [COL_CNT_W-1:0] col_cnt_out,
    output logic signed [WIN_SUM_W-1:0] acc_sum_out,
    output logic        [WIN_CNT_W-1:0] acc_cnt_out
);

    logic signed [COL_SUM_W-1:0] sum_reg;
    logic        [COL_CNT_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            sum_reg <= col_sum_in;
            cnt_reg <= col_cnt_in;
        end
    end

    assign col_sum_out = sum_reg;
    assign col_cnt_out = cnt_reg;
    assign acc_sum_out = use_en ? acc_sum_in + WIN_SUM_W'(sum_reg) : acc_sum_in;
    assign acc_cnt_out = use_en ? acc_cnt_in + WIN_CNT_W'(cnt_reg) : acc_cnt_in;

endmodule

@@ hdl/mbaf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbaf_div
// Bit-serial signed divide of the window sum by the known count, truncating
// toward zero; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbaf_div #(
    parameter int SUM_W = 13,
    parameter int CNT_W = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic        [CNT_W-1:0] divisor,
    output logic                    done,
    output logic signed [7:0]       quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  mag_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  den_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    rem_sh;
    logic              fits;
    logic signed [SUM_W-1:0] q_signed;

    always_comb begin
        rem_sh   = {rem_reg, mag_reg[SUM_W-1]};
        fits     = rem_sh >= {1'b0, den_reg};
        q_signed = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(SUM_W);
            neg_reg  <= dividend[SUM_W-1];
            mag_reg  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_reg  <= '0;
            den_reg  <= divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= CNT_W'(rem_sh - {1'b0, den_reg});
                mag_reg <= {mag_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[CNT_W-1:0];
                mag_reg <= {mag_reg[SUM_W-2:0], 1'b0};
            end
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_signed[7:0];

endmodule

@@ hdl/masked_box_average_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_box_average_filter
// Mean of the known cells in a (2h+1) square window of a raster-order grid.
// ----------------------------------------------------------------------------
// Takes one grid cell per word in raster order and returns, for each interior
// centre, the truncated mean of the known (not -1) window cells, or -1 when
// none is known, with its column, row and an end-of-frame flag. Each cell is
// read from the line RAMs and summed; an emitting cell then passes through
// the bit-serial divider, which forms the mean one quotient bit per cycle, or
// goes straight to the output when no window cell is known and the divider is
// skipped. A result word still waiting in the output register adds the cycles
// it waits. Previous rows sit in 2*MAX_HALF+1 line RAMs; a row of column cells
// shifts once per cell and forms the window sum. The result register lets the
// next cell be taken while a word waits.
// ----------------------------------------------------------------------------
module masked_box_average_filter #(
    parameter int MAX_WIDTH = mbaf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HALF  = mbaf_pkg::MAX_HALF_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [mbaf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbaf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [mbaf_pkg::CELL_W-1:0]   s_cell_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mbaf_pkg::COL_OUT_W-1:0]       m_center_col,
    output logic [mbaf_pkg::ROW_W-1:0]           m_center_row,
    output logic signed [mbaf_pkg::CELL_W-1:0]   m_filtered_value,
    output logic                                 m_last_of_frame
);

    import mbaf_pkg::*;

    localparam int WIN       = 2 * MAX_HALF + 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int HALF_W    = $clog2(MAX_HALF + 1);
    localparam int SLOT_W    = $clog2(WIN);
    localparam int COL_SUM_W = CELL_W + $clog2(WIN);
    localparam int COL_CNT_W = $clog2(WIN + 1);
    localparam int WIN_SUM_W = CELL_W + $clog2(WIN * WIN);
    localparam int WIN_CNT_W = $clog2(WIN * WIN + 1);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(WIN - 1)) ? '0 : s + 1'b1;
    endfunction

    // configuration
    logic [GW_W-1:0] grid_width_reg;
    logic [GH_W-1:0] grid_height_reg;
    logic [HW_W-1:0] half_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            half_window_reg <= HALF_WINDOW_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GW_W-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[GH_W-1:0];
                CFG_HALF_WINDOW: half_window_reg <= cfg_data[HW_W-1:0];
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [COL_W:0]    w_eff;
    logic [GH_W-1:0]   h_eff;
    logic [HALF_W-1:0] k_now;
    logic [HALF_W:0]   span_now;
    logic              wrap_col;
    logic [COL_W-1:0]  c_now;
    logic [ROW_W:0]    r_pre;
    logic [ROW_W-1:0]  r_now;
    logic [SLOT_W-1:0] slot_now;
    logic [COL_W:0]    c_inc;
    logic [ROW_W:0]    r_inc;
    logic              accept;

    // per-cell registers
    logic signed [CELL_W-1:0] cell_reg;
    logic [COL_W-1:0]         c_reg;
    logic [ROW_W-1:0]         r_reg;
    logic [SLOT_W-1:0]        cur_slot_reg;
    logic [HALF_W-1:0]        k_reg;
    logic [HALF_W:0]          span_reg;
    logic                     emit_reg;
    logic                     last_reg;
    logic                     none_reg;

    always_comb begin
        if (grid_width_reg == '0) begin
            w_eff = (COL_W+1)'(1);
        end else if (int'(grid_width_reg) > MAX_WIDTH) begin
            w_eff = (COL_W+1)'(MAX_WIDTH);
        end else begin
            w_eff = (COL_W+1)'(grid_width_reg);
        end
        if (grid_height_reg == '0) begin
            h_eff = GH_W'(1);
        end else if (int'(grid_height_reg) > MAX_HEIGHT) begin
            h_eff = GH_W'(MAX_HEIGHT);
        end else begin
            h_eff = grid_height_reg;
        end
        k_now    = (int'(half_window_reg) > MAX_HALF) ? HALF_W'(MAX_HALF)
                                                      : HALF_W'(half_window_reg);
        span_now = {k_now, 1'b0};

        wrap_col = {1'b0, col_reg} >= w_eff;
        c_now    = wrap_col ? '0 : col_reg;
        r_pre    = wrap_col ? {1'b0, row_reg} + 1'b1 : {1'b0, row_reg};
        r_now    = (GH_W'(r_pre) >= h_eff) ? '0 : r_pre[ROW_W-1:0];
        slot_now = wrap_col ? slot_inc(slot_reg) : slot_reg;

        c_inc     = {1'b0, c_now} + 1'b1;
        r_inc     = {1'b0, r_now} + 1'b1;
        col_next  = c_inc[COL_W-1:0];
        row_next  = r_now;
        slot_next = slot_now;
        if (c_inc >= w_eff) begin
            col_next  = '0;
            row_next  = (GH_W'(r_inc) >= h_eff) ? '0 : r_inc[ROW_W-1:0];
            slot_next = slot_inc(slot_now);
        end
    end

    // line stores
    logic [CELL_W-1:0] rd_data [WIN];

    for (genvar j = 0; j < WIN; j++) begin : g_line
        mbaf_ram #(
            .WIDTH(CELL_W),
            .DEPTH(MAX_WIDTH)
        ) u_ram (
            .aclk (aclk),
            .we   (accept && (slot_now == SLOT_W'(j))),
            .waddr(c_now),
            .wdata(s_cell_value),
            .raddr(c_now),
            .rdata(rd_data[j])
        );
    end

    // column of the new cell
    logic signed [COL_SUM_W-1:0] new_col_sum;
    logic        [COL_CNT_W-1:0] new_col_cnt;

    always_comb begin
        logic [SLOT_W:0]          dr;
        logic signed [CELL_W-1:0] v;
        new_col_sum = '0;
        new_col_cnt = '0;
        for (int j = 0; j < WIN; j++) begin
            dr = (cur_slot_reg >= SLOT_W'(j))
               ? (SLOT_W+1)'(cur_slot_reg) - (SLOT_W+1)'(j)
               : (SLOT_W+1)'(cur_slot_reg) + (SLOT_W+1)'(WIN - j);
            v  = (cur_slot_reg == SLOT_W'(j)) ? cell_reg : $signed(rd_data[j]);
            if (int'(dr) <= int'(span_reg) && v != UNKNOWN_CELL) begin
                new_col_sum = new_col_sum + COL_SUM_W'(v);
                new_col_cnt = new_col_cnt + 1'b1;
            end
        end
    end

    // chain of column cells
    logic signed [COL_SUM_W-1:0] ch_sum [WIN];
    logic        [COL_CNT_W-1:0] ch_cnt [WIN];
    logic signed [WIN_SUM_W-1:0] acc_sum [WIN];
    logic        [WIN_CNT_W-1:0] acc_cnt [WIN];

    for (genvar i = 0; i < WIN; i++) begin : g_cell
        mbaf_cell #(
            .COL_SUM_W(COL_SUM_W),
            .COL_CNT_W(COL_CNT_W),
            .WIN_SUM_W(WIN_SUM_W),
            .WIN_CNT_W(WIN_CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .shift      (state_reg == ST_READ),
            .use_en     (i <= int'(span_reg)),
            .col_sum_in ((i == 0) ? new_col_sum : ch_sum[(i == 0) ? 0 : i - 1]),
            .col_cnt_in ((i == 0) ? new_col_cnt : ch_cnt[(i == 0) ? 0 : i - 1]),
            .acc_sum_in ((i == 0) ? '0 : acc_sum[(i == 0) ? 0 : i - 1]),
            .acc_cnt_in ((i == 0) ? '0 : acc_cnt[(i == 0) ? 0 : i - 1]),
            .col_sum_out(ch_sum[i]),
            .col_cnt_out(ch_cnt[i]),
            .acc_sum_out(acc_sum[i]),
            .acc_cnt_out(acc_cnt[i])
        );
    end

    logic signed [WIN_SUM_W-1:0] win_sum;
    logic        [WIN_CNT_W-1:0] win_cnt;
    logic                        div_start;
    logic                        div_done;
    logic signed [CELL_W-1:0]    div_q;
    logic                        out_load;

    assign win_sum = acc_sum[WIN-1];
    assign win_cnt = acc_cnt[WIN-1];

    mbaf_div #(
        .SUM_W(WIN_SUM_W),
        .CNT_W(WIN_CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(win_sum),
        .divisor (win_cnt),
        .done    (div_done),
        .quotient(div_q)
    );

    // control
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_READ;
            ST_READ: state_next = ST_SUM;
            ST_SUM: begin
                if (!emit_reg) begin
                    state_next = ST_IDLE;
                end else if (win_cnt == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (!m_valid || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready   = 1'b1;
            ST_SUM:  div_start = emit_reg && (win_cnt != '0);
            ST_OUT:  out_load  = !m_valid || m_ready;
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                slot_reg <= slot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cell_reg     <= s_cell_value;
            c_reg        <= c_now;
            r_reg        <= r_now;
            cur_slot_reg <= slot_now;
            k_reg        <= k_now;
            span_reg     <= span_now;
            emit_reg     <= int'(c_now) >= int'(span_now) && int'(r_now) >= int'(span_now);
            last_reg     <= int'(c_now) == int'(w_eff) - 1 && int'(r_now) == int'(h_eff) - 1;
        end
        if (state_reg == ST_SUM) begin
            none_reg <= win_cnt == '0;
        end
    end

    // result register
    logic                        m_valid_reg;
    logic [COL_OUT_W-1:0]        m_col_reg;
    logic [ROW_W-1:0]            m_row_reg;
    logic signed [CELL_W-1:0]    m_value_reg;
    logic                        m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_col_reg   <= COL_OUT_W'(int'(c_reg) - int'(k_reg));
            m_row_reg   <= ROW_W'(int'(r_reg) - int'(k_reg));
            m_value_reg <= none_reg ? UNKNOWN_CELL : div_q;
            m_last_reg  <= last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_center_col     = m_col_reg;
    assign m_center_row     = m_row_reg;
    assign m_filtered_value = m_value_reg;
    assign m_last_of_frame  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> win_cnt != '0)
        else $error("divide started with no known cell");

    a_read_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_READ)
        else $error("accepted word not followed by line read");

    a_out_from_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result word raised outside output state");

    a_emit_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM && emit_reg) |-> int'(c_reg) >= int'(span_reg))
        else $error("emit for a centre without a full window");
`endif

endmodule
